### src/ptps_pkg.sv
// Shared types and constants of the PTP PI clock servo.
// Used by the register file, the top level and the port checker.
`timescale 1ns / 1ps
`default_nettype none

package ptps_pkg;

    // Register widths and data port width
    localparam int LIMIT_W    = 30;
    localparam int PPM_W      = 20;
    localparam int BASE_W     = 17;
    localparam int CFG_DATA_W = 30;
    localparam int CFG_IDX_W  = 2;

    // Field widths
    localparam int SEC_W   = 32;
    localparam int NSEC_W  = 30;
    localparam int PHASE_W = 63;
    localparam int FREQ_W  = 21;
    localparam int DIV_W   = 16;
    localparam int CNT_W   = 32;
    localparam int INTEG_W = 31;

    // Stages from input register to result register, result register included
    localparam int PIPE_DEPTH = 9;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INTEGRAL_LIMIT = 2'd0,
        CFG_MAX_ADJUST_PPM = 2'd1,
        CFG_BASE_FREQUENCY = 2'd2
    } cfg_index_t;

    // Register reset values
    localparam logic [LIMIT_W-1:0] INTEGRAL_LIMIT_RST = 30'd1000000;
    localparam logic [PPM_W-1:0]   MAX_ADJUST_RST     = 20'd1000;
    localparam logic [BASE_W-1:0]  BASE_FREQ_RST      = 17'd32768;

    // Seconds to nanoseconds
    localparam logic signed [30:0] NS_PER_SEC = 31'sd1000000000;

    // x / 10 for x < 2^31: (x * ceil(2^34 / 10)) >> 34
    localparam logic [30:0] DIV10_MUL   = 31'd1717986919;
    localparam int          DIV10_SHIFT = 34;
    localparam int          Q10_W       = 27;

    // x / 1e6 for x < 2^37: ((x >> 6) * ceil(2^45 / 15625)) >> 45
    localparam int          PPM_PRESHIFT = 6;
    localparam logic [31:0] PPM_MUL      = 32'd2251799814;
    localparam int          PPM_SHIFT    = 45;
    localparam int          DIVQ_W       = 18;

    // Divider clamp
    localparam logic signed [20:0] DIV_MIN = 21'sd1;
    localparam logic signed [20:0] DIV_MAX = 21'sd65535;

    // Register file contents seen by the datapath
    typedef struct packed {
        logic [LIMIT_W-1:0] integral_limit;
        logic [PPM_W-1:0]   max_adjust_ppm;
        logic [BASE_W-1:0]  base_frequency;
    } cfg_t;

endpackage

`default_nettype wire

### src/ptps_if.sv
// Valid/ready channel interfaces: sync event beats in, servo result beats out.
// Depends on ptps_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ptps_evt_if;
    logic                              valid;
    logic                              ready;
    logic [ptps_pkg::SEC_W-1:0]        ref_seconds;
    logic [ptps_pkg::NSEC_W-1:0]       ref_nanoseconds;
    logic [ptps_pkg::SEC_W-1:0]        local_seconds_in;
    logic [ptps_pkg::NSEC_W-1:0]       local_nanoseconds_in;

    modport source (output valid, ref_seconds, ref_nanoseconds, local_seconds_in,
                    local_nanoseconds_in, input ready);
    modport sink   (input valid, ref_seconds, ref_nanoseconds, local_seconds_in,
                    local_nanoseconds_in, output ready);
endinterface

interface ptps_res_if;
    logic                                valid;
    logic                                ready;
    logic signed [ptps_pkg::PHASE_W-1:0] phase_error;
    logic signed [ptps_pkg::FREQ_W-1:0]  freq_correction;
    logic [ptps_pkg::DIV_W-1:0]          divider_value;
    logic [ptps_pkg::CNT_W-1:0]          event_count;

    modport source (output valid, phase_error, freq_correction, divider_value,
                    event_count, input ready);
    modport sink   (input valid, phase_error, freq_correction, divider_value,
                    event_count, output ready);
endinterface

`default_nettype wire

### src/ptps_cfg_regs.sv
// Configuration register file of the servo: limits and nominal RTC frequency.
// Depends on ptps_pkg for widths, indexes and reset values.
`timescale 1ns / 1ps
`default_nettype none

module ptps_cfg_regs (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [ptps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ptps_pkg::CFG_DATA_W-1:0]    cfg_data,
    output ptps_pkg::cfg_t                          cfg
);

    ptps_pkg::cfg_t cfg_reg;
    ptps_pkg::cfg_t cfg_next;

    // Decode the write; unknown indexes leave everything as is
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                ptps_pkg::CFG_INTEGRAL_LIMIT:
                    cfg_next.integral_limit = cfg_data[ptps_pkg::LIMIT_W-1:0];
                ptps_pkg::CFG_MAX_ADJUST_PPM:
                    cfg_next.max_adjust_ppm = cfg_data[ptps_pkg::PPM_W-1:0];
                ptps_pkg::CFG_BASE_FREQUENCY:
                    cfg_next.base_frequency = cfg_data[ptps_pkg::BASE_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.integral_limit <= ptps_pkg::INTEGRAL_LIMIT_RST;
            cfg_reg.max_adjust_ppm <= ptps_pkg::MAX_ADJUST_RST;
            cfg_reg.base_frequency <= ptps_pkg::BASE_FREQ_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### src/ptp_pi_rtc_divider_servo_top.sv
// PTP PI clock servo: sync timestamps in, RTC prescaler reload out.
// Depends on ptps_pkg, ptps_if.sv (channel interfaces) and ptps_cfg_regs.
`timescale 1ns / 1ps
`default_nettype none

// One sync event beat gives one result beat: phase error (reference minus
// local time, ns), clamped PI frequency correction (ppm), the new 16-bit RTC
// divider and a wrapping event count. The block is a nine-register pipeline
// and takes one beat every clock cycle while no stall holds it; the integral
// accumulator is updated as each beat moves from s2 to s3. Each stage holds
// its beat only while the stage after it is full and stalled, so events keep
// flowing in behind a result that waits to be taken. The user must write
// registers through the plain write port only while no beat is in flight;
// the block itself does not enforce this.

module ptp_pi_rtc_divider_servo_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [ptps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ptps_pkg::CFG_DATA_W-1:0]    cfg_data,
    ptps_evt_if.sink                                sync_evt,
    ptps_res_if.source                              servo_res
);

    localparam int D = ptps_pkg::PIPE_DEPTH;

    ptps_pkg::cfg_t cfg;

    ptps_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // ---------------------------------------------------------------
    // Pipeline control: stage i loads when empty or when it moves on
    // ---------------------------------------------------------------
    logic [D-1:0] valid_reg;
    logic [D-1:0] load;

    always_comb
    begin
        load[D-1] = !valid_reg[D-1] || servo_res.ready;
        for (int i = D - 2; i >= 0; i--)
        begin
            load[i] = !valid_reg[i] || load[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (load[0])
            begin
                valid_reg[0] <= sync_evt.valid;
            end
            for (int i = 1; i < D; i++)
            begin
                if (load[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    assign sync_evt.ready = load[0];

    // ---------------------------------------------------------------
    // Control state: event counter and phase integral
    // ---------------------------------------------------------------
    logic [ptps_pkg::CNT_W-1:0]          sync_cnt_reg;
    logic [ptps_pkg::CNT_W-1:0]          sync_cnt_next;
    logic signed [ptps_pkg::INTEG_W-1:0] integral_reg;
    logic signed [ptps_pkg::INTEG_W-1:0] integral_next;
    logic                                evt_beat;
    logic                                integ_step;

    assign evt_beat      = sync_evt.valid && load[0];
    assign sync_cnt_next = sync_cnt_reg + 32'd1;

    // ---------------------------------------------------------------
    // Stage registers (payload, no reset)
    // ---------------------------------------------------------------
    // s0: captured event
    logic [ptps_pkg::SEC_W-1:0]          s0_ref_sec_reg;
    logic [ptps_pkg::NSEC_W-1:0]         s0_ref_ns_reg;
    logic [ptps_pkg::SEC_W-1:0]          s0_loc_sec_reg;
    logic [ptps_pkg::NSEC_W-1:0]         s0_loc_ns_reg;
    logic [ptps_pkg::CNT_W-1:0]          s0_cnt_reg;
    // s1: seconds difference scaled to ns
    logic signed [ptps_pkg::PHASE_W-1:0] s1_sec_ns_reg;
    logic signed [ptps_pkg::NSEC_W:0]    s1_dns_reg;
    logic [ptps_pkg::CNT_W-1:0]          s1_cnt_reg;
    // s2: phase error
    logic signed [ptps_pkg::PHASE_W-1:0] s2_phase_reg;
    logic [ptps_pkg::CNT_W-1:0]          s2_cnt_reg;
    // s3: phase error and updated integral
    logic signed [ptps_pkg::PHASE_W-1:0] s3_phase_reg;
    logic signed [ptps_pkg::INTEG_W-1:0] s3_integ_reg;
    logic [ptps_pkg::CNT_W-1:0]          s3_cnt_reg;
    // s4: integral / 10 as sign and magnitude
    logic signed [ptps_pkg::PHASE_W-1:0] s4_phase_reg;
    logic [ptps_pkg::Q10_W-1:0]          s4_q10_reg;
    logic                                s4_q10_neg_reg;
    logic [ptps_pkg::CNT_W-1:0]          s4_cnt_reg;
    // s5: clamped frequency correction
    logic signed [ptps_pkg::PHASE_W-1:0] s5_phase_reg;
    logic signed [ptps_pkg::FREQ_W-1:0]  s5_freq_reg;
    logic [ptps_pkg::CNT_W-1:0]          s5_cnt_reg;
    // s6: base * |correction|
    logic signed [ptps_pkg::PHASE_W-1:0] s6_phase_reg;
    logic signed [ptps_pkg::FREQ_W-1:0]  s6_freq_reg;
    logic [36:0]                         s6_scaled_reg;
    logic [ptps_pkg::CNT_W-1:0]          s6_cnt_reg;
    // s7: divider step magnitude
    logic signed [ptps_pkg::PHASE_W-1:0] s7_phase_reg;
    logic signed [ptps_pkg::FREQ_W-1:0]  s7_freq_reg;
    logic [ptps_pkg::DIVQ_W-1:0]         s7_divq_reg;
    logic [ptps_pkg::CNT_W-1:0]          s7_cnt_reg;
    // result register
    logic signed [ptps_pkg::PHASE_W-1:0] res_phase_reg;
    logic signed [ptps_pkg::FREQ_W-1:0]  res_freq_reg;
    logic [ptps_pkg::DIV_W-1:0]          res_div_reg;
    logic [ptps_pkg::CNT_W-1:0]          res_cnt_reg;

    // ---------------------------------------------------------------
    // Stage logic
    // ---------------------------------------------------------------
    logic signed [32:0]                  c0_dsec;
    logic signed [ptps_pkg::NSEC_W:0]    c0_dns;
    logic signed [63:0]                  c0_sec_ns;
    logic signed [ptps_pkg::PHASE_W-1:0] c1_phase;
    logic signed [63:0]                  c3_isum;
    logic signed [63:0]                  c3_ilim;
    logic [ptps_pkg::INTEG_W-1:0]        c4_iabs;
    logic [61:0]                         c4_prod;
    logic signed [63:0]                  c5_q10;
    logic signed [63:0]                  c5_fsum;
    logic signed [63:0]                  c5_flim;
    logic signed [ptps_pkg::FREQ_W-1:0]  c5_freq;
    logic [ptps_pkg::PPM_W-1:0]          c6_fabs;
    logic [62:0]                         c7_prod;
    logic signed [20:0]                  c8_base;
    logic signed [20:0]                  c8_step;
    logic signed [20:0]                  c8_dsum;
    logic [ptps_pkg::DIV_W-1:0]          c8_div;

    // s0 -> s1: split differences, seconds scaled by 1e9
    always_comb
    begin
        c0_dsec   = $signed({1'b0, s0_ref_sec_reg}) - $signed({1'b0, s0_loc_sec_reg});
        c0_dns    = $signed({1'b0, s0_ref_ns_reg}) - $signed({1'b0, s0_loc_ns_reg});
        c0_sec_ns = 64'(c0_dsec) * 64'(ptps_pkg::NS_PER_SEC);
    end

    // s1 -> s2: full phase error
    assign c1_phase = s1_sec_ns_reg + ptps_pkg::PHASE_W'(s1_dns_reg);

    // s2 -> s3: integral accumulate and symmetric clamp
    always_comb
    begin
        c3_isum = 64'(integral_reg) + 64'(s2_phase_reg);
        c3_ilim = $signed({34'd0, cfg.integral_limit});
        priority if (c3_isum > c3_ilim)
        begin
            integral_next = ptps_pkg::INTEG_W'(c3_ilim);
        end
        else if (c3_isum < -c3_ilim)
        begin
            integral_next = ptps_pkg::INTEG_W'(-c3_ilim);
        end
        else
        begin
            integral_next = ptps_pkg::INTEG_W'(c3_isum);
        end
    end

    assign integ_step = valid_reg[2] && load[3];

    // s3 -> s4: |integral| / 10 by reciprocal multiply
    always_comb
    begin
        c4_iabs = s3_integ_reg[ptps_pkg::INTEG_W-1]
                ? ptps_pkg::INTEG_W'(-s3_integ_reg) : ptps_pkg::INTEG_W'(s3_integ_reg);
        c4_prod = 62'(c4_iabs) * 62'(ptps_pkg::DIV10_MUL);
    end

    // s4 -> s5: proportional plus integral, clamped to the ppm limit
    always_comb
    begin
        c5_q10  = s4_q10_neg_reg ? -$signed({37'd0, s4_q10_reg})
                                 :  $signed({37'd0, s4_q10_reg});
        c5_fsum = 64'(s4_phase_reg) + c5_q10;
        c5_flim = $signed({44'd0, cfg.max_adjust_ppm});
        priority if (c5_fsum > c5_flim)
        begin
            c5_freq = ptps_pkg::FREQ_W'(c5_flim);
        end
        else if (c5_fsum < -c5_flim)
        begin
            c5_freq = ptps_pkg::FREQ_W'(-c5_flim);
        end
        else
        begin
            c5_freq = ptps_pkg::FREQ_W'(c5_fsum);
        end
    end

    // s5 -> s6: base frequency times |correction|
    assign c6_fabs = s5_freq_reg[ptps_pkg::FREQ_W-1]
                   ? ptps_pkg::PPM_W'(-s5_freq_reg) : ptps_pkg::PPM_W'(s5_freq_reg);

    // s6 -> s7: divide by one million (drop 2^6, then reciprocal of 15625)
    assign c7_prod = 63'(s6_scaled_reg[36:ptps_pkg::PPM_PRESHIFT]) * 63'(ptps_pkg::PPM_MUL);

    // s7 -> result: divider, truncated toward zero, clamped to 1..65535
    always_comb
    begin
        c8_base = $signed({4'd0, cfg.base_frequency});
        c8_step = s7_freq_reg[ptps_pkg::FREQ_W-1] ? -$signed({3'd0, s7_divq_reg})
                                                  :  $signed({3'd0, s7_divq_reg});
        c8_dsum = c8_base - 21'sd1 + c8_step;
        priority if (c8_dsum < ptps_pkg::DIV_MIN)
        begin
            c8_div = ptps_pkg::DIV_W'(ptps_pkg::DIV_MIN);
        end
        else if (c8_dsum > ptps_pkg::DIV_MAX)
        begin
            c8_div = ptps_pkg::DIV_W'(ptps_pkg::DIV_MAX);
        end
        else
        begin
            c8_div = c8_dsum[ptps_pkg::DIV_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Control state registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_cnt_reg <= '0;
            integral_reg <= '0;
        end
        else
        begin
            if (evt_beat)
            begin
                sync_cnt_reg <= sync_cnt_next;
            end
            if (integ_step)
            begin
                integral_reg <= integral_next;
            end
        end
    end

    // ---------------------------------------------------------------
    // Payload registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            s0_ref_sec_reg <= sync_evt.ref_seconds;
            s0_ref_ns_reg  <= sync_evt.ref_nanoseconds;
            s0_loc_sec_reg <= sync_evt.local_seconds_in;
            s0_loc_ns_reg  <= sync_evt.local_nanoseconds_in;
            s0_cnt_reg     <= sync_cnt_next;
        end
        if (load[1])
        begin
            s1_sec_ns_reg <= c0_sec_ns[ptps_pkg::PHASE_W-1:0];
            s1_dns_reg    <= c0_dns;
            s1_cnt_reg    <= s0_cnt_reg;
        end
        if (load[2])
        begin
            s2_phase_reg <= c1_phase;
            s2_cnt_reg   <= s1_cnt_reg;
        end
        if (load[3])
        begin
            s3_phase_reg <= s2_phase_reg;
            s3_integ_reg <= integral_next;
            s3_cnt_reg   <= s2_cnt_reg;
        end
        if (load[4])
        begin
            s4_phase_reg   <= s3_phase_reg;
            s4_q10_reg     <= c4_prod[ptps_pkg::DIV10_SHIFT+ptps_pkg::Q10_W-1:
                                      ptps_pkg::DIV10_SHIFT];
            s4_q10_neg_reg <= s3_integ_reg[ptps_pkg::INTEG_W-1];
            s4_cnt_reg     <= s3_cnt_reg;
        end
        if (load[5])
        begin
            s5_phase_reg <= s4_phase_reg;
            s5_freq_reg  <= c5_freq;
            s5_cnt_reg   <= s4_cnt_reg;
        end
        if (load[6])
        begin
            s6_phase_reg  <= s5_phase_reg;
            s6_freq_reg   <= s5_freq_reg;
            s6_scaled_reg <= 37'(cfg.base_frequency) * 37'(c6_fabs);
            s6_cnt_reg    <= s5_cnt_reg;
        end
        if (load[7])
        begin
            s7_phase_reg <= s6_phase_reg;
            s7_freq_reg  <= s6_freq_reg;
            s7_divq_reg  <= c7_prod[ptps_pkg::PPM_SHIFT+ptps_pkg::DIVQ_W-1:ptps_pkg::PPM_SHIFT];
            s7_cnt_reg   <= s6_cnt_reg;
        end
        if (load[8])
        begin
            res_phase_reg <= s7_phase_reg;
            res_freq_reg  <= s7_freq_reg;
            res_div_reg   <= c8_div;
            res_cnt_reg   <= s7_cnt_reg;
        end
    end

    // Result channel
    assign servo_res.valid           = valid_reg[D-1];
    assign servo_res.phase_error     = res_phase_reg;
    assign servo_res.freq_correction = res_freq_reg;
    assign servo_res.divider_value   = res_div_reg;
    assign servo_res.event_count     = res_cnt_reg;

endmodule

`default_nettype wire

### src/ptps_checker.sv
// Port-level checker for the PTP PI clock servo, bound to the top level.
// Depends on ptps_pkg for widths and pipeline depth.
`timescale 1ns / 1ps
`default_nettype none

module ptps_checker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                evt_valid,
    input  wire logic                                evt_ready,
    input  wire logic                                res_valid,
    input  wire logic                                res_ready,
    input  wire logic signed [ptps_pkg::PHASE_W-1:0] phase_error,
    input  wire logic signed [ptps_pkg::FREQ_W-1:0]  freq_correction,
    input  wire logic [ptps_pkg::DIV_W-1:0]          divider_value,
    input  wire logic [ptps_pkg::CNT_W-1:0]          event_count
);

    logic                       evt_beat;
    logic                       res_beat;
    logic [3:0]                 inflight_reg;
    logic [ptps_pkg::CNT_W-1:0] delivered_reg;

    assign evt_beat = evt_valid && evt_ready;
    assign res_beat = res_valid && res_ready;

    // Beats taken but not yet delivered, and beats delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg  <= '0;
            delivered_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_reg + 4'(evt_beat) - 4'(res_beat);
            if (res_beat)
            begin
                delivered_reg <= delivered_reg + 32'd1;
            end
        end
    end

    // Never more beats inside than pipeline registers
    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= 4'(ptps_pkg::PIPE_DEPTH))
        else $error("more beats in flight than pipeline stages");

    // Results come out in order, none lost or repeated
    a_count_order: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> event_count == delivered_reg + 32'd1)
        else $error("event count out of sequence");

    // Divider is always a usable reload value
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> divider_value != '0)
        else $error("divider value of zero");

    // A stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(phase_error)
            && $stable(freq_correction) && $stable(divider_value) && $stable(event_count))
        else $error("stalled result changed");

endmodule

bind ptp_pi_rtc_divider_servo_top ptps_checker u_ptps_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .evt_valid       (sync_evt.valid),
    .evt_ready       (sync_evt.ready),
    .res_valid       (servo_res.valid),
    .res_ready       (servo_res.ready),
    .phase_error     (servo_res.phase_error),
    .freq_correction (servo_res.freq_correction),
    .divider_value   (servo_res.divider_value),
    .event_count     (servo_res.event_count)
);

`default_nettype wire

### dv/tb_ptp_pi_rtc_divider_servo_top.sv
// Self-checking testbench for the PTP PI clock servo top level.
// Depends on ptps_pkg, the channel interfaces in ptps_if.sv and the RTL top.
`timescale 1ns / 1ps

module tb_ptp_pi_rtc_divider_servo_top;

    localparam longint NS_PER_S   = 64'sd1000000000;
    localparam longint PPM_DIV    = 64'sd1000000;
    localparam longint DIV_FLOOR  = 64'sd1;
    localparam longint DIV_CEIL   = 64'sd65535;
    // Largest timestamp that a 32-bit seconds field can carry, plus one nanosecond
    localparam longint TS_LIMIT   = 64'sd4294967296000000000;
    localparam logic [ptps_pkg::NSEC_W-1:0]    NS_TOP        = 30'd999999999;
    localparam logic [ptps_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
    localparam int     PHASE_BEATS = 205;

    typedef struct packed {
        logic [ptps_pkg::PHASE_W-1:0] phase_error;
        logic [ptps_pkg::FREQ_W-1:0]  freq_correction;
        logic [ptps_pkg::DIV_W-1:0]   divider_value;
        logic [ptps_pkg::CNT_W-1:0]   event_count;
    } servo_result_t;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             cfg_we;
    logic [ptps_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [ptps_pkg::CFG_DATA_W-1:0]  cfg_data;

    ptps_evt_if sync_evt_bus ();
    ptps_res_if servo_res_bus ();

    ptp_pi_rtc_divider_servo_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sync_evt  (sync_evt_bus),
        .servo_res (servo_res_bus)
    );

    always #6 clk = ~clk;

    // Servo model state and register copies
    logic [ptps_pkg::LIMIT_W-1:0] model_limit = ptps_pkg::INTEGRAL_LIMIT_RST;
    logic [ptps_pkg::PPM_W-1:0]   model_ppm   = ptps_pkg::MAX_ADJUST_RST;
    logic [ptps_pkg::BASE_W-1:0]  model_base  = ptps_pkg::BASE_FREQ_RST;
    longint                       model_integral = 0;
    logic [ptps_pkg::CNT_W-1:0]   model_events   = '0;

    servo_result_t pending_results[$];
    int            error_count = 0;
    bit            src_idle_en  = 1'b1;
    bit            sink_idle_en = 1'b1;

    function automatic longint clamp_sym(longint v, longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    // PI servo: phase error, clamped integral, clamped correction, divider
    function automatic servo_result_t servo_predict(
            logic [ptps_pkg::SEC_W-1:0] rs, logic [ptps_pkg::NSEC_W-1:0] rns,
            logic [ptps_pkg::SEC_W-1:0] ls, logic [ptps_pkg::NSEC_W-1:0] lns);
        longint        phase;
        longint        freq;
        longint        base;
        longint        div;
        servo_result_t r;
        phase = (longint'({32'd0, rs}) * NS_PER_S + longint'({34'd0, rns}))
              - (longint'({32'd0, ls}) * NS_PER_S + longint'({34'd0, lns}));
        model_integral = clamp_sym(model_integral + phase, longint'({34'd0, model_limit}));
        freq = clamp_sym(phase + model_integral / 10, longint'({44'd0, model_ppm}));
        base = longint'({47'd0, model_base});
        div  = base - 1 + (base * freq) / PPM_DIV;
        if (div < DIV_FLOOR)
            div = DIV_FLOOR;
        if (div > DIV_CEIL)
            div = DIV_CEIL;
        model_events = model_events + 1'b1;
        r.phase_error     = phase[ptps_pkg::PHASE_W-1:0];
        r.freq_correction = freq[ptps_pkg::FREQ_W-1:0];
        r.divider_value   = div[ptps_pkg::DIV_W-1:0];
        r.event_count     = model_events;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
        error_count++;
        if (error_count <= 10)
            $display("%0t: %s mismatch: expected %h got %h", $realtime, what, want, got);
    endtask

    // One sync event beat, with an optional random gap in front of it
    task automatic send_event(logic [ptps_pkg::SEC_W-1:0] rs, logic [ptps_pkg::NSEC_W-1:0] rns,
                              logic [ptps_pkg::SEC_W-1:0] ls, logic [ptps_pkg::NSEC_W-1:0] lns);
        int gap;
        gap = 0;
        if (src_idle_en && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 7);
        if (gap > 0)
        begin
            sync_evt_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sync_evt_bus.valid                <= 1'b1;
        sync_evt_bus.ref_seconds          <= rs;
        sync_evt_bus.ref_nanoseconds      <= rns;
        sync_evt_bus.local_seconds_in     <= ls;
        sync_evt_bus.local_nanoseconds_in <= lns;
        do
            @(posedge clk);
        while (!(sync_evt_bus.valid && sync_evt_bus.ready));
        pending_results.push_back(servo_predict(rs, rns, ls, lns));
    endtask

    // Stop sending and wait until every predicted result has been taken
    task automatic drain_results();
        sync_evt_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic write_reg(logic [ptps_pkg::CFG_IDX_W-1:0] idx,
                             logic [ptps_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            ptps_pkg::CFG_INTEGRAL_LIMIT: model_limit = data[ptps_pkg::LIMIT_W-1:0];
            ptps_pkg::CFG_MAX_ADJUST_PPM: model_ppm   = data[ptps_pkg::PPM_W-1:0];
            ptps_pkg::CFG_BASE_FREQUENCY: model_base  = data[ptps_pkg::BASE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [ptps_pkg::CFG_DATA_W-1:0] lim,
                              logic [ptps_pkg::CFG_DATA_W-1:0] ppm,
                              logic [ptps_pkg::CFG_DATA_W-1:0] base);
        drain_results();
        write_reg(ptps_pkg::CFG_INTEGRAL_LIMIT, lim);
        write_reg(ptps_pkg::CFG_MAX_ADJUST_PPM, ppm);
        write_reg(ptps_pkg::CFG_BASE_FREQUENCY, base);
        cfg_we <= 1'b0;
    endtask

    // Random sync event: mostly a plausible local time with an offset on a
    // log scale, then raw fields, then field extremes.
    task automatic gen_event(output logic [ptps_pkg::SEC_W-1:0] rs,
                             output logic [ptps_pkg::NSEC_W-1:0] rns,
                             output logic [ptps_pkg::SEC_W-1:0] ls,
                             output logic [ptps_pkg::NSEC_W-1:0] lns);
        int     pick;
        int     k;
        longint mag;
        longint delta;
        longint t0;
        longint t;
        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            ls  = $urandom;
            lns = ($urandom_range(0, 9) == 0) ? '0
                : ptps_pkg::NSEC_W'($urandom_range(0, 999999999));
            k   = $urandom_range(0, 34);
            mag = longint'({$urandom, $urandom}) & ((longint'(1) <<< k) - 1);
            delta = $urandom_range(0, 1) ? -mag : mag;
            t0 = longint'({32'd0, ls}) * NS_PER_S + longint'({34'd0, lns});
            t  = t0 + delta;
            if (t < 0 || t >= TS_LIMIT)
                t = t0 - delta;
            rs  = ptps_pkg::SEC_W'(t / NS_PER_S);
            rns = ptps_pkg::NSEC_W'(t % NS_PER_S);
        end
        else if (pick < 85)
        begin
            rs  = $urandom;
            rns = ptps_pkg::NSEC_W'($urandom);
            ls  = $urandom;
            lns = ptps_pkg::NSEC_W'($urandom);
        end
        else
        begin
            rs  = $urandom_range(0, 1) ? '1 : '0;
            ls  = $urandom_range(0, 1) ? '1 : '0;
            case ($urandom_range(0, 2))
                0:       rns = '0;
                1:       rns = NS_TOP;
                default: rns = '1;
            endcase
            case ($urandom_range(0, 2))
                0:       lns = '0;
                1:       lns = NS_TOP;
                default: lns = '1;
            endcase
        end
    endtask

    // Result sink: random stall bursts, every beat checked against the model
    initial
    begin
        servo_result_t want;
        int            stall_left;
        stall_left = 0;
        servo_res_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (servo_res_bus.valid && servo_res_bus.ready)
                begin
                    if (pending_results.size() == 0)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display("%0t: result beat with no event pending, phase %h",
                                     $realtime, servo_res_bus.phase_error);
                    end
                    else
                    begin
                        want = pending_results.pop_front();
                        if (servo_res_bus.phase_error !== want.phase_error)
                            report_mismatch("phase_error", 64'(want.phase_error),
                                            64'(servo_res_bus.phase_error));
                        if (servo_res_bus.freq_correction !== want.freq_correction)
                            report_mismatch("freq_correction", 64'(want.freq_correction),
                                            64'(servo_res_bus.freq_correction));
                        if (servo_res_bus.divider_value !== want.divider_value)
                            report_mismatch("divider_value", 64'(want.divider_value),
                                            64'(servo_res_bus.divider_value));
                        if (servo_res_bus.event_count !== want.event_count)
                            report_mismatch("event_count", 64'(want.event_count),
                                            64'(servo_res_bus.event_count));
                    end
                end
                if (stall_left == 0 && sink_idle_en && $urandom_range(0, 4) == 0)
                    stall_left = $urandom_range(1, 7);
                if (stall_left > 0)
                begin
                    servo_res_bus.ready <= 1'b0;
                    stall_left--;
                end
                else
                    servo_res_bus.ready <= 1'b1;
            end
        end
    end

    // Reset register values, zero and plus/minus 500 ns offsets, full
    // range seconds and nanoseconds past 999999999
    task automatic test_reset_defaults();
        send_event(32'd0, 30'd0, 32'd0, 30'd0);
        send_event(32'd100, 30'd500, 32'd100, 30'd0);
        send_event(32'd100, 30'd0, 32'd100, 30'd500);
        send_event('1, NS_TOP, 32'd0, 30'd0);
        send_event(32'd0, 30'd0, '1, NS_TOP);
        send_event(32'd7, '1, 32'd7, 30'd0);
        send_event(32'd7, 30'd0, 32'd7, '1);
        send_event('1, '1, '1, '1);
        // local subsecond unavailable
        send_event(32'd55, 30'd123456789, 32'd55, 30'd0);
    endtask

    // Zero limits, widest limits, base frequency at zero and one, masked
    // write data and a write to an unused index
    task automatic test_register_extremes();
        set_config(30'd0, 30'd0, 30'd32768);
        send_event(32'd1, 30'd1000000, 32'd1, 30'd0);
        send_event(32'd1, 30'd0, 32'd1, 30'd5);
        set_config(30'd1000000000, 30'd1000000, 30'd65536);
        send_event(32'd10, 30'd0, 32'd0, 30'd0);
        send_event(32'd0, 30'd0, 32'd10, 30'd0);
        send_event(32'd3, 30'd1234, 32'd3, 30'd0);
        set_config('1, '1, '1);
        send_event(32'd2000, 30'd0, 32'd0, 30'd0);
        send_event(32'd0, 30'd0, 32'd2000, 30'd0);
        set_config(30'd1000000, 30'd1000, 30'd0);
        send_event(32'd9, 30'd0, 32'd9, 30'd0);
        drain_results();
        write_reg(CFG_SPARE_IDX, 30'h155);
        cfg_we <= 1'b0;
        send_event(32'd9, 30'd700, 32'd9, 30'd0);
        // upper bits of the ppm write fall outside the register
        set_config(30'd1000000, 30'h3FF00064, 30'd1);
        send_event(32'd9, 30'd50, 32'd9, 30'd0);
    endtask

    task automatic run_phase(int beats);
        logic [ptps_pkg::SEC_W-1:0]  rs;
        logic [ptps_pkg::NSEC_W-1:0] rns;
        logic [ptps_pkg::SEC_W-1:0]  ls;
        logic [ptps_pkg::NSEC_W-1:0] lns;
        repeat (beats)
        begin
            gen_event(rs, rns, ls, lns);
            send_event(rs, rns, ls, lns);
        end
    endtask

    // Random traffic over several register settings; the last one runs
    // with no gaps from the source and the sink always ready.
    task automatic test_random_traffic();
        set_config(30'd1000000, 30'd1000, 30'd32768);
        run_phase(PHASE_BEATS);
        set_config(ptps_pkg::CFG_DATA_W'($urandom_range(0, 1000000000)),
                   ptps_pkg::CFG_DATA_W'($urandom_range(0, 1000000)),
                   ptps_pkg::CFG_DATA_W'($urandom_range(1, 65536)));
        run_phase(PHASE_BEATS);
        set_config('1, '1, '1);
        run_phase(PHASE_BEATS);
        set_config(30'd0, 30'd0, 30'd1);
        run_phase(PHASE_BEATS);
        set_config(30'd1000000000, 30'd1000000, 30'd65536);
        run_phase(PHASE_BEATS);
        set_config(30'd5000, 30'd50000, 30'd32768);
        run_phase(PHASE_BEATS);
        set_config(30'd1000000, 30'd1000, 30'd32768);
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        run_phase(PHASE_BEATS);
    endtask

    // Event counter wrap needs 2^32 beats and is out of reach of this run.
    initial
    begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= ptps_pkg::CFG_INTEGRAL_LIMIT;
        cfg_data  <= '0;
        sync_evt_bus.valid                <= 1'b0;
        sync_evt_bus.ref_seconds          <= '0;
        sync_evt_bus.ref_nanoseconds      <= '0;
        sync_evt_bus.local_seconds_in     <= '0;
        sync_evt_bus.local_nanoseconds_in <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_register_extremes();
        test_random_traffic();

        drain_results();
        repeat (ptps_pkg::PIPE_DEPTH + 4) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog
    initial
    begin
        #10000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
